### rtl/ceo_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ceo_pkg
// Shared constants for the circular elimination order block.
// ----------------------------------------------------------------------------
package ceo_pkg;

   localparam int TAG_W           = 8;
   localparam int STEP_W          = 10;
   localparam int STEP_CNT_W      = $clog2(STEP_W);
   localparam int MAX_MEMBERS_DEF = 64;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_COUNT    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_REVERSE_ORDER = 1'b1;

   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_RUN    = 1'b1;

endpackage : ceo_pkg
`default_nettype wire

### rtl/ceo_mod_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ceo_mod_unit
// Restoring remainder unit: step count modulo living count, one bit a cycle.
// ----------------------------------------------------------------------------
module ceo_mod_unit
   import ceo_pkg::*;
#(
   parameter int MAX_MEMBERS = MAX_MEMBERS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic [STEP_W-1:0]                    dividend,
   input  wire logic [$clog2(MAX_MEMBERS+1)-1:0]     divisor,
   output logic                                      done,
   output logic [$clog2(MAX_MEMBERS+1)-1:0]          remainder
);

   localparam int CNT_W = $clog2(MAX_MEMBERS + 1);

   logic                  busy_ff;
   logic                  done_ff;
   logic [STEP_CNT_W-1:0] cnt_ff;
   logic [STEP_W-1:0]     dvd_ff;
   logic [CNT_W-1:0]      rem_ff;

   logic [CNT_W:0]        trial;
   logic [CNT_W:0]        diff;
   logic [CNT_W-1:0]      rem_in;

   always_comb begin
      trial  = {rem_ff, dvd_ff[STEP_W-1]};
      diff   = trial - {1'b0, divisor};
      rem_in = (trial >= {1'b0, divisor}) ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         dvd_ff  <= '0;
         rem_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            dvd_ff  <= dividend;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            dvd_ff <= {dvd_ff[STEP_W-2:0], 1'b0};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == STEP_CNT_W'(STEP_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule : ceo_mod_unit
`default_nettype wire

### rtl/circular_elimination_order.sv
`default_nettype none
// ----------------------------------------------------------------------------
// circular_elimination_order
// Josephus elimination over a ring of member tags held in link memories.
//
// req_ beats with cmd append store one tag (dropped and flagged when full);
// a run beat builds the ring and removes members one by one, each removal
// giving one rsp_ beat, the survivor coming last with is_survivor and last.
// csr_ writes set step_count (index 0) and reverse_order (index 1); take
// them only while the block is idle. csr_ready is always high.
// A run first builds the ring, writing one link per member, then for each
// removal runs the remainder unit and reads one link memory entry per
// step walked. The survivor is read without the remainder unit.
// req_stall is high for the whole run.
// Results leave through an output register; while rsp_stall holds a beat
// the block finds the next result, then holds it inside until the beat leaves.
// Reset clears counts and registers (step_count resets to 1); the memories
// are not cleared, since every entry is written before a run reads it.
// ----------------------------------------------------------------------------
module circular_elimination_order
   import ceo_pkg::*;
#(
   parameter int MAX_MEMBERS = MAX_MEMBERS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_cmd,
   input  wire logic [TAG_W-1:0]      req_member_tag,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [TAG_W-1:0]           rsp_member_tag_res,
   output logic                       rsp_is_survivor,
   output logic                       rsp_last,
   output logic                       rsp_overflow,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [STEP_W-1:0]     csr_data
);

   localparam int IDX_W = $clog2(MAX_MEMBERS);
   localparam int CNT_W = $clog2(MAX_MEMBERS + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_BUILD, ST_CHECK, ST_MOD, ST_WALK,
      ST_RM_RD, ST_RM_WR, ST_SV_RD, ST_SV_WR, ST_EMIT
   } state_type;

   state_type         state_ff;
   logic [STEP_W-1:0] step_ff;
   logic              reverse_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              dropped_ff;
   logic [CNT_W-1:0]  living_ff;
   logic [IDX_W-1:0]  start_ff;
   logic [IDX_W-1:0]  prev_pos_ff;
   logic [IDX_W-1:0]  cur_ff;
   logic [IDX_W-1:0]  prev_ff;
   logic [IDX_W-1:0]  k_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [TAG_W-1:0]  res_tag_ff;
   logic              res_last_ff;
   logic              rsp_valid_ff;
   logic [TAG_W-1:0]  rsp_tag_ff;
   logic              rsp_last_ff;
   logic              rsp_overflow_ff;

   logic [TAG_W-1:0]  tag_mem [MAX_MEMBERS];
   logic [IDX_W-1:0]  link_mem [MAX_MEMBERS];
   logic [TAG_W-1:0]  tag_q;
   logic [IDX_W-1:0]  link_q;

   logic              req_accept;
   logic              tag_we;
   logic [IDX_W-1:0]  tag_raddr;
   logic              link_we;
   logic [IDX_W-1:0]  link_waddr;
   logic [IDX_W-1:0]  link_wdata;
   logic [IDX_W-1:0]  link_raddr;
   logic [IDX_W-1:0]  build_link;
   logic [CNT_W-1:0]  last_idx;
   logic              build_end;
   logic              rsp_load;
   logic              mod_start;
   logic              mod_done;
   logic [CNT_W-1:0]  mod_rem;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign tag_we     = req_accept && (req_cmd == CMD_APPEND) &&
                       (count_ff < CNT_W'(MAX_MEMBERS));
   assign rsp_load   = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign mod_start  = (state_ff == ST_CHECK) && (living_ff != CNT_W'(1));

   always_comb begin
      last_idx  = living_ff - 1'b1;
      build_end = (CNT_W'(idx_ff) == last_idx);
      if (reverse_ff) begin
         build_link = (idx_ff == '0) ? last_idx[IDX_W-1:0] : idx_ff - 1'b1;
      end else begin
         build_link = build_end ? '0 : idx_ff + 1'b1;
      end
      link_we    = (state_ff == ST_BUILD) || (state_ff == ST_RM_WR);
      link_waddr = (state_ff == ST_BUILD) ? idx_ff : prev_ff;
      link_wdata = (state_ff == ST_BUILD) ? build_link : link_q;
      case (state_ff)
         ST_MOD:  link_raddr = start_ff;
         ST_WALK: link_raddr = link_q;
         default: link_raddr = cur_ff;
      endcase
      tag_raddr = (state_ff == ST_SV_RD) ? start_ff : cur_ff;
   end

   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[count_ff[IDX_W-1:0]] <= req_member_tag;
      end
      tag_q <= tag_mem[tag_raddr];
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      link_q <= link_mem[link_raddr];
   end

   ceo_mod_unit #(
      .MAX_MEMBERS (MAX_MEMBERS)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (step_ff),
      .divisor   (living_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         step_ff         <= STEP_W'(1);
         reverse_ff      <= 1'b0;
         count_ff        <= '0;
         dropped_ff      <= 1'b0;
         living_ff       <= '0;
         start_ff        <= '0;
         prev_pos_ff     <= '0;
         cur_ff          <= '0;
         prev_ff         <= '0;
         k_ff            <= '0;
         idx_ff          <= '0;
         res_tag_ff      <= '0;
         res_last_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         rsp_tag_ff      <= '0;
         rsp_last_ff     <= 1'b0;
         rsp_overflow_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_STEP_COUNT:    step_ff    <= csr_data;
               CSR_REVERSE_ORDER: reverse_ff <= csr_data[0];
               default:           ;
            endcase
         end
         if (rsp_valid_ff && !rsp_stall && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  if (req_cmd == CMD_APPEND) begin
                     if (tag_we) begin
                        count_ff <= count_ff + 1'b1;
                     end else begin
                        dropped_ff <= 1'b1;
                     end
                  end else if (count_ff == '0) begin
                     dropped_ff <= 1'b0;
                  end else begin
                     living_ff <= count_ff;
                     idx_ff    <= '0;
                     start_ff  <= '0;
                     if (reverse_ff && (count_ff != CNT_W'(1))) begin
                        prev_pos_ff <= IDX_W'(1);
                     end else begin
                        prev_pos_ff <= IDX_W'(count_ff - 1'b1);
                     end
                     state_ff <= ST_BUILD;
                  end
               end
            end
            ST_BUILD: begin
               idx_ff <= idx_ff + 1'b1;
               if (build_end) begin
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               state_ff <= (living_ff == CNT_W'(1)) ? ST_SV_RD : ST_MOD;
            end
            ST_MOD: begin
               if (mod_done) begin
                  cur_ff   <= start_ff;
                  prev_ff  <= prev_pos_ff;
                  k_ff     <= mod_rem[IDX_W-1:0];
                  state_ff <= (mod_rem == '0) ? ST_RM_RD : ST_WALK;
               end
            end
            ST_WALK: begin
               prev_ff <= cur_ff;
               cur_ff  <= link_q;
               k_ff    <= k_ff - 1'b1;
               if (k_ff == IDX_W'(1)) begin
                  state_ff <= ST_RM_RD;
               end
            end
            ST_RM_RD: begin
               state_ff <= ST_RM_WR;
            end
            ST_RM_WR: begin
               start_ff    <= link_q;
               prev_pos_ff <= prev_ff;
               res_tag_ff  <= tag_q;
               res_last_ff <= 1'b0;
               state_ff    <= ST_EMIT;
            end
            ST_SV_RD: begin
               state_ff <= ST_SV_WR;
            end
            ST_SV_WR: begin
               res_tag_ff  <= tag_q;
               res_last_ff <= 1'b1;
               state_ff    <= ST_EMIT;
            end
            ST_EMIT: begin
               if (rsp_load) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_tag_ff      <= res_tag_ff;
                  rsp_last_ff     <= res_last_ff;
                  rsp_overflow_ff <= dropped_ff;
                  if (res_last_ff) begin
                     count_ff   <= '0;
                     dropped_ff <= 1'b0;
                     state_ff   <= ST_IDLE;
                  end else begin
                     living_ff <= living_ff - 1'b1;
                     state_ff  <= ST_CHECK;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_member_tag_res = rsp_tag_ff;
   assign rsp_is_survivor    = rsp_last_ff;
   assign rsp_last           = rsp_last_ff;
   assign rsp_overflow       = rsp_overflow_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_MEMBERS))
      else $error("member count above capacity");

   a_walk_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (k_ff != '0))
      else $error("walk entered with no steps left");

   a_living_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_CHECK) || (state_ff == ST_MOD)) |->
      ((living_ff != '0) && (living_ff <= count_ff)))
      else $error("living count out of range");

   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && res_last_ff) |=>
      ((state_ff == ST_IDLE) && (count_ff == '0) && rsp_valid_ff && rsp_last_ff))
      else $error("run did not close after survivor beat");
`endif

endmodule : circular_elimination_order
`default_nettype wire
